FILE: hdl/ct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_pkg
// Shared types, kind codes, character codes and byte classes of the tokenizer.
// ----------------------------------------------------------------------------
package ct_pkg;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_BLOCK, M_BLOCK_STAR, M_LINE,
        M_DIR, M_DIR_ESC, M_DIR_SLASH, M_DIR_BLOCK, M_DIR_BLOCK_STAR,
        M_DOL, M_DOL_SLASH, M_DOL_BLOCK, M_DOL_BLOCK_STAR, M_DOL_LINE,
        M_META, M_CHAR_FIRST, M_CHAR, M_STR, M_NUM, M_IDENT
    } mode_t;

    localparam logic [5:0] K_UNKNOWN   = 6'd0;
    localparam logic [5:0] K_DOLLAR    = 6'd11;
    localparam logic [5:0] K_DIVIDE    = 6'd23;
    localparam logic [5:0] K_DIRECTIVE = 6'd27;
    localparam logic [5:0] K_META      = 6'd28;
    localparam logic [5:0] K_CHAR      = 6'd29;
    localparam logic [5:0] K_STRING    = 6'd30;
    localparam logic [5:0] K_NUMBER    = 6'd31;
    localparam logic [5:0] K_IDENT     = 6'd32;
    localparam logic [5:0] K_END       = 6'd33;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_EOT    = 8'hFF;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] pos;
        logic [23:0] len;
        logic [23:0] line;
        logic [23:0] col;
        logic [63:0] hash;
        logic        last;
    } tok_t;

    // Up to three tokens produced by one byte.
    typedef struct packed {
        logic [1:0]       n;
        tok_t [2:0]       t;
    } em_t;

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A || b == 8'h0C;
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_idc(input logic [7:0] b);
        return is_dig(b) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)
            || b == 8'h5F;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] b);
        logic [5:0] k;
        unique case (b)
            8'h3B:   k = 6'd1;
            8'h5C:   k = 6'd2;
            8'h7B:   k = 6'd3;
            8'h7D:   k = 6'd4;
            8'h28:   k = 6'd5;
            8'h29:   k = 6'd6;
            8'h5B:   k = 6'd7;
            8'h5D:   k = 6'd8;
            8'h7E:   k = 6'd9;
            8'h21:   k = 6'd10;
            8'h24:   k = 6'd11;
            8'h25:   k = 6'd12;
            8'h5E:   k = 6'd13;
            8'h26:   k = 6'd14;
            8'h2A:   k = 6'd15;
            8'h7C:   k = 6'd16;
            8'h2E:   k = 6'd17;
            8'h2C:   k = 6'd18;
            8'h3F:   k = 6'd19;
            8'h3A:   k = 6'd20;
            8'h2B:   k = 6'd21;
            8'h2D:   k = 6'd22;
            8'h2F:   k = 6'd23;
            8'h3D:   k = 6'd24;
            8'h3E:   k = 6'd25;
            8'h3C:   k = 6'd26;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ct_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_channels
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface ct_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface ct_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [23:0] start_position;
    logic [23:0] token_length;
    logic [23:0] line_number;
    logic [23:0] column_number;
    logic [15:0] source_file;
    logic [63:0] text_hash;
    logic        last_of_run;
    modport source (output valid, output token_kind, output start_position,
                    output token_length, output line_number, output column_number,
                    output source_file, output text_hash, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input start_position,
                    input token_length, input line_number, input column_number,
                    input source_file, input text_hash, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/ct_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_scanner
// Scan state and the per-byte step; yields up to three tokens per byte.
// ----------------------------------------------------------------------------
module ct_scanner #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_NESTING   = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  in_byte,
    output ct_pkg::em_t      em
);

    localparam int PB = POSITION_BITS;
    localparam int NB = $clog2(MAX_NESTING + 1);
    localparam logic [PB-1:0] PMAX = '1;
    localparam logic [NB-1:0] NMAX = NB'(MAX_NESTING);

    typedef struct packed {
        ct_pkg::mode_t mode;
        logic [PB-1:0] tstart;
        logic [PB-1:0] tcount;
        logic [PB-1:0] tline;
        logic [PB-1:0] tcol;
        logic [PB-1:0] pos;
        logic [PB-1:0] line;
        logic [PB-1:0] col;
        logic [PB-1:0] ppos;
        logic [PB-1:0] pline;
        logic [PB-1:0] pcol;
        logic [63:0]   hash;
        logic [NB-1:0] depth;
    } st_t;

    typedef struct packed {
        st_t         s;
        ct_pkg::em_t e;
        logic        redo;
    } res_t;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == PMAX) ? v : v + PB'(1);
    endfunction

    function automatic logic [63:0] sext(input logic [7:0] b);
        return {{56{b[7]}}, b};
    endfunction

    function automatic logic [23:0] fit(input logic [PB-1:0] v);
        logic [PB+23:0] w;
        w = {24'd0, v};
        return w[23:0];
    endfunction

    function automatic ct_pkg::tok_t mk(input logic [5:0] kind, input logic [PB-1:0] pos,
                                        input logic [PB-1:0] len, input logic [PB-1:0] line,
                                        input logic [PB-1:0] col, input logic [63:0] hash);
        ct_pkg::tok_t t;
        t.kind = kind;
        t.pos  = fit(pos);
        t.len  = fit(len);
        t.line = fit(line);
        t.col  = fit(col);
        t.hash = hash;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic ct_pkg::em_t push(input ct_pkg::em_t e, input ct_pkg::tok_t t);
        ct_pkg::em_t r;
        r = e;
        if (e.n != 2'd3)
        begin
            r.t[e.n] = t;
            r.n = e.n + 2'd1;
        end
        return r;
    endfunction

    function automatic st_t add_text(input st_t s, input logic [7:0] b);
        st_t r;
        r = s;
        // hash * 65599 as shifts and adds
        r.hash   = (s.hash << 16) + (s.hash << 6) - s.hash + sext(b);
        r.tcount = sat_inc(s.tcount);
        return r;
    endfunction

    function automatic st_t begin_text(input st_t s, input logic [PB-1:0] pos,
                                       input logic [PB-1:0] line, input logic [PB-1:0] col);
        st_t r;
        r = s;
        r.tstart = pos;
        r.tline  = line;
        r.tcol   = col;
        r.hash   = '0;
        r.tcount = '0;
        return r;
    endfunction

    function automatic st_t begin_after(input st_t s);
        return begin_text(s, sat_inc(s.pos), s.line, sat_inc(s.col));
    endfunction

    function automatic st_t hold_slash(input st_t s);
        st_t r;
        r = s;
        r.ppos  = s.pos;
        r.pline = s.line;
        r.pcol  = s.col;
        return r;
    endfunction

    function automatic ct_pkg::tok_t tok_text(input st_t s, input logic [5:0] kind);
        return mk(kind, s.tstart, s.tcount, s.tline, s.tcol, s.hash);
    endfunction

    function automatic ct_pkg::tok_t tok_dollar(input st_t s);
        return mk(ct_pkg::K_DOLLAR, s.tstart, PB'(1), s.tline, s.tcol, sext(ct_pkg::CH_DOLLAR));
    endfunction

    function automatic ct_pkg::tok_t tok_slash(input st_t s);
        return mk(ct_pkg::K_DIVIDE, s.ppos, PB'(1), s.pline, s.pcol, sext(ct_pkg::CH_SLASH));
    endfunction

    function automatic res_t run(input st_t s, input ct_pkg::em_t e, input logic [7:0] b,
                                 input logic [7:0] p1, input logic [7:0] p2);
        res_t r;
        r.s = s;
        r.e = e;
        r.redo = 1'b0;
        unique case (s.mode)
            ct_pkg::M_IDLE:
            begin
                if (ct_pkg::is_ws(b))
                begin
                    r.s = s;
                end
                else if (b == ct_pkg::CH_SLASH)
                begin
                    r.s = hold_slash(s);
                    r.s.mode = ct_pkg::M_SLASH;
                end
                else if (b == ct_pkg::CH_HASH)
                begin
                    r.s = begin_after(s);
                    r.s.mode = ct_pkg::M_DIR;
                end
                else if (b == ct_pkg::CH_DOLLAR)
                begin
                    r.s = begin_text(s, s.pos, s.line, s.col);
                    r.s.mode = ct_pkg::M_DOL;
                end
                else if (b == ct_pkg::CH_SQUOTE)
                begin
                    r.s = begin_after(s);
                    r.s.mode = ct_pkg::M_CHAR_FIRST;
                end
                else if (b == ct_pkg::CH_DQUOTE)
                begin
                    r.s = begin_after(s);
                    r.s.mode = ct_pkg::M_STR;
                end
                else if (ct_pkg::is_idc(b))
                begin
                    r.s = add_text(begin_text(s, s.pos, s.line, s.col), b);
                    r.s.mode = ct_pkg::is_dig(b) ? ct_pkg::M_NUM : ct_pkg::M_IDENT;
                end
                else
                begin
                    r.e = push(e, mk(ct_pkg::punct_kind(b), s.pos, PB'(1), s.line, s.col,
                                     sext(b)));
                end
            end
            ct_pkg::M_SLASH:
            begin
                if (b == ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_BLOCK;
                else if (b == ct_pkg::CH_SLASH)
                    r.s.mode = ct_pkg::M_LINE;
                else
                begin
                    r.e = push(e, tok_slash(s));
                    r.s.mode = ct_pkg::M_IDLE;
                    r.redo = 1'b1;
                end
            end
            ct_pkg::M_BLOCK:
            begin
                if (b == ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_BLOCK_STAR;
            end
            ct_pkg::M_BLOCK_STAR:
            begin
                if (b == ct_pkg::CH_SLASH)
                    r.s.mode = ct_pkg::M_IDLE;
                else if (b != ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_BLOCK;
            end
            ct_pkg::M_LINE:
            begin
                if (b == ct_pkg::CH_NL)
                    r.s.mode = ct_pkg::M_IDLE;
            end
            ct_pkg::M_DIR:
            begin
                if (b == ct_pkg::CH_NL)
                begin
                    r.e = push(e, tok_text(s, ct_pkg::K_DIRECTIVE));
                    r.s.mode = ct_pkg::M_IDLE;
                    r.redo = 1'b1;
                end
                else if (b == ct_pkg::CH_BSLASH)
                begin
                    r.s = add_text(s, b);
                    r.s.mode = ct_pkg::M_DIR_ESC;
                end
                else if (b == ct_pkg::CH_SLASH)
                    r.s.mode = ct_pkg::M_DIR_SLASH;
                else
                    r.s = add_text(s, b);
            end
            ct_pkg::M_DIR_ESC:
            begin
                r.s = add_text(s, b);
                r.s.mode = ct_pkg::M_DIR;
            end
            ct_pkg::M_DIR_SLASH:
            begin
                if (b == ct_pkg::CH_SLASH)
                begin
                    r.e = push(e, tok_text(s, ct_pkg::K_DIRECTIVE));
                    r.s.mode = ct_pkg::M_LINE;
                end
                else if (b == ct_pkg::CH_STAR)
                begin
                    r.s = add_text(add_text(s, ct_pkg::CH_SLASH), b);
                    r.s.mode = ct_pkg::M_DIR_BLOCK;
                end
                else
                begin
                    r.s = add_text(s, ct_pkg::CH_SLASH);
                    r.s.mode = ct_pkg::M_DIR;
                    r.redo = 1'b1;
                end
            end
            ct_pkg::M_DIR_BLOCK:
            begin
                r.s = add_text(s, b);
                if (b == ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_DIR_BLOCK_STAR;
            end
            ct_pkg::M_DIR_BLOCK_STAR:
            begin
                r.s = add_text(s, b);
                if (b == ct_pkg::CH_SLASH)
                    r.s.mode = ct_pkg::M_DIR;
                else if (b != ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_DIR_BLOCK;
            end
            ct_pkg::M_DOL:
            begin
                if (ct_pkg::is_ws(b))
                    r.s = s;
                else if (b == ct_pkg::CH_SLASH)
                begin
                    r.s = hold_slash(s);
                    r.s.mode = ct_pkg::M_DOL_SLASH;
                end
                else if (b == ct_pkg::CH_LPAREN)
                begin
                    r.s = begin_after(s);
                    r.s.depth = '0;
                    r.s.mode = ct_pkg::M_META;
                end
                else
                begin
                    r.e = push(e, tok_dollar(s));
                    r.s.mode = ct_pkg::M_IDLE;
                    r.redo = 1'b1;
                end
            end
            ct_pkg::M_DOL_SLASH:
            begin
                if (b == ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_DOL_BLOCK;
                else if (b == ct_pkg::CH_SLASH)
                    r.s.mode = ct_pkg::M_DOL_LINE;
                else
                begin
                    r.e = push(push(e, tok_dollar(s)), tok_slash(s));
                    r.s.mode = ct_pkg::M_IDLE;
                    r.redo = 1'b1;
                end
            end
            ct_pkg::M_DOL_BLOCK:
            begin
                if (b == ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_DOL_BLOCK_STAR;
            end
            ct_pkg::M_DOL_BLOCK_STAR:
            begin
                if (b == ct_pkg::CH_SLASH)
                    r.s.mode = ct_pkg::M_DOL;
                else if (b != ct_pkg::CH_STAR)
                    r.s.mode = ct_pkg::M_DOL_BLOCK;
            end
            ct_pkg::M_DOL_LINE:
            begin
                if (b == ct_pkg::CH_NL)
                    r.s.mode = ct_pkg::M_DOL;
            end
            ct_pkg::M_META:
            begin
                if (b == ct_pkg::CH_RPAREN && s.depth == '0)
                begin
                    r.e = push(e, tok_text(s, ct_pkg::K_META));
                    r.s.mode = ct_pkg::M_IDLE;
                end
                else
                begin
                    r.s = add_text(s, b);
                    if (b == ct_pkg::CH_RPAREN)
                        r.s.depth = s.depth - NB'(1);
                    else if (b == ct_pkg::CH_LPAREN && s.depth < NMAX)
                        r.s.depth = s.depth + NB'(1);
                end
            end
            ct_pkg::M_CHAR_FIRST:
            begin
                r.s = add_text(s, b);
                r.s.mode = ct_pkg::M_CHAR;
            end
            ct_pkg::M_CHAR:
            begin
                if (b == ct_pkg::CH_SQUOTE && (p1 != ct_pkg::CH_BSLASH || p2 == ct_pkg::CH_BSLASH))
                begin
                    r.e = push(e, tok_text(s, ct_pkg::K_CHAR));
                    r.s.mode = ct_pkg::M_IDLE;
                end
                else
                    r.s = add_text(s, b);
            end
            ct_pkg::M_STR:
            begin
                if (b == ct_pkg::CH_DQUOTE && p1 != ct_pkg::CH_BSLASH)
                begin
                    r.e = push(e, tok_text(s, ct_pkg::K_STRING));
                    r.s.mode = ct_pkg::M_IDLE;
                end
                else
                    r.s = add_text(s, b);
            end
            ct_pkg::M_NUM:
            begin
                if (ct_pkg::is_dig(b))
                    r.s = add_text(s, b);
                else
                begin
                    r.e = push(e, tok_text(s, ct_pkg::K_NUMBER));
                    r.s.mode = ct_pkg::M_IDLE;
                    r.redo = 1'b1;
                end
            end
            ct_pkg::M_IDENT:
            begin
                if (ct_pkg::is_idc(b))
                    r.s = add_text(s, b);
                else
                begin
                    r.e = push(e, tok_text(s, ct_pkg::K_IDENT));
                    r.s.mode = ct_pkg::M_IDLE;
                    r.redo = 1'b1;
                end
            end
            default:
            begin
                r.s.mode = ct_pkg::M_IDLE;
                r.redo = 1'b1;
            end
        endcase
        return r;
    endfunction

    st_t         st_reg, st_next;
    logic [15:0] prior_reg, prior_next;
    ct_pkg::em_t em_next;

    always_comb
    begin
        res_t        r1, r2, r3;
        st_t         s;
        ct_pkg::em_t e;
        e = '0;
        s = st_reg;
        prior_next = prior_reg;
        r1 = '0;
        r2 = '0;
        r3 = '0;
        if (in_byte == ct_pkg::CH_NUL || in_byte == ct_pkg::CH_EOT)
        begin
            unique case (st_reg.mode) inside
                ct_pkg::M_SLASH:
                    e = push(e, tok_slash(st_reg));
                ct_pkg::M_DIR, ct_pkg::M_DIR_ESC, ct_pkg::M_DIR_BLOCK,
                ct_pkg::M_DIR_BLOCK_STAR:
                    e = push(e, tok_text(st_reg, ct_pkg::K_DIRECTIVE));
                ct_pkg::M_DIR_SLASH:
                    e = push(e, tok_text(add_text(st_reg, ct_pkg::CH_SLASH),
                                         ct_pkg::K_DIRECTIVE));
                ct_pkg::M_DOL, ct_pkg::M_DOL_BLOCK, ct_pkg::M_DOL_BLOCK_STAR,
                ct_pkg::M_DOL_LINE:
                    e = push(e, tok_dollar(st_reg));
                ct_pkg::M_DOL_SLASH:
                    e = push(push(e, tok_dollar(st_reg)), tok_slash(st_reg));
                ct_pkg::M_META:
                    e = push(e, tok_text(st_reg, ct_pkg::K_META));
                ct_pkg::M_CHAR_FIRST, ct_pkg::M_CHAR:
                    e = push(e, tok_text(st_reg, ct_pkg::K_CHAR));
                ct_pkg::M_STR:
                    e = push(e, tok_text(st_reg, ct_pkg::K_STRING));
                ct_pkg::M_NUM:
                    e = push(e, tok_text(st_reg, ct_pkg::K_NUMBER));
                ct_pkg::M_IDENT:
                    e = push(e, tok_text(st_reg, ct_pkg::K_IDENT));
                default:
                    e = e;
            endcase
            e = push(e, mk(ct_pkg::K_END, st_reg.pos, '0, st_reg.line, st_reg.col, '0));
            s = '0;
            s.mode = ct_pkg::M_IDLE;
            prior_next = '0;
        end
        else
        begin
            // at most three passes: directive slash, directive, idle
            r1 = run(st_reg, e, in_byte, prior_reg[7:0], prior_reg[15:8]);
            r2 = r1;
            if (r1.redo)
                r2 = run(r1.s, r1.e, in_byte, prior_reg[7:0], prior_reg[15:8]);
            r3 = r2;
            if (r1.redo && r2.redo)
                r3 = run(r2.s, r2.e, in_byte, prior_reg[7:0], prior_reg[15:8]);
            s = r3.s;
            e = r3.e;
            s.pos = sat_inc(st_reg.pos);
            if (in_byte == ct_pkg::CH_NL)
            begin
                s.line = sat_inc(st_reg.line);
                s.col  = '0;
            end
            else
                s.col = sat_inc(st_reg.col);
            prior_next = {prior_reg[7:0], in_byte};
        end
        for (int i = 0; i < 3; i++)
            e.t[i].last = (e.n == 2'(i + 1));
        em_next = e;
        st_next = s;
    end

    assign em = fire ? em_next : '0;

    // all-zero state is idle between tokens
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '0;
            prior_reg   <= '0;
        end
        else if (fire)
        begin
            st_reg    <= st_next;
            prior_reg <= prior_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/ct_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_queue
// Token queue: takes up to three beats a cycle, gives one when popped.
// ----------------------------------------------------------------------------
module ct_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ct_pkg::em_t  em,
    input  wire logic         pop,
    output logic              room,
    output logic              nonempty,
    output ct_pkg::tok_t      head
);

    localparam int D  = ct_pkg::Q_DEPTH;
    localparam int AW = ct_pkg::Q_AW;

    ct_pkg::tok_t      mem [D];
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [AW:0]       count_reg, count_next;

    assign room     = count_reg <= (AW+1)'(D - 3);
    assign nonempty = count_reg != '0;
    assign head     = mem[head_reg];

    always_comb
    begin
        head_next  = head_reg + AW'(pop);
        tail_next  = tail_reg + AW'(em.n);
        count_next = count_reg + (AW+1)'(em.n) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            if (2'(i) < em.n)
                mem[AW'(tail_reg + AW'(i))] <= em.t[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg + (AW+1)'(em.n)) <= (AW+1)'(D))
        else $error("token queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("token queue popped while empty");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (em.n == 2'd0 && !pop) |=> $stable(count_reg) && $stable(head_reg))
        else $error("token queue moved without a beat");
`endif

endmodule
`default_nettype wire

FILE: hdl/c_source_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c_source_tokenizer
// Streaming C source tokenizer: one byte in per beat, tokens out per beat.
// ----------------------------------------------------------------------------
// Takes one source byte per clock and reports each token (kind, offset,
// length, line, column, file number, text hash). A byte is held in an input
// register until the queue has room, then the scanner step works it
// and writes the zero to three tokens it completes into an eight-entry token
// queue, which drains one token per cycle while the token sink is ready.
// Sustained rate is one byte per clock while tokens are taken as fast as
// they arise; the input stalls only when the queue has fewer than three
// free entries. A byte of 0 or 0xFF ends the text with an end token and
// restarts offsets at zero. Write the file number only while the block is
// idle.
module c_source_tokenizer #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_NESTING   = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    ct_text_if.sink          text,
    ct_token_if.source       token
);

    logic [15:0]   file_number_reg;
    logic [7:0]    byte_reg;
    logic          byte_valid_reg;
    logic          room;
    logic          fire;
    logic          nonempty;
    ct_pkg::em_t   em;
    ct_pkg::tok_t  head;

    // work the held byte once the queue can take a full run of tokens
    assign fire       = byte_valid_reg && room;
    // take a new beat when the holding register is empty or empties this cycle
    assign text.ready = !byte_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_number_reg <= '0;
            byte_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                file_number_reg <= cfg_data;
            if (text.ready)
                byte_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
            byte_reg <= text.text_byte;
    end

    ct_scanner #(
        .POSITION_BITS (POSITION_BITS),
        .MAX_NESTING   (MAX_NESTING)
    ) u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (byte_reg),
        .em      (em)
    );

    ct_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .em       (em),
        .pop      (nonempty && token.ready),
        .room     (room),
        .nonempty (nonempty),
        .head     (head)
    );

    // drive the token beat straight from the queue head
    assign token.valid          = nonempty;
    assign token.token_kind     = head.kind;
    assign token.start_position = head.pos;
    assign token.token_length   = head.len;
    assign token.line_number    = head.line;
    assign token.column_number  = head.col;
    assign token.source_file    = file_number_reg;
    assign token.text_hash      = head.hash;
    assign token.last_of_run    = head.last;

`ifndef NO_ASSERTIONS
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid_reg && !fire) |=> byte_valid_reg && $stable(byte_reg))
        else $error("held byte lost while stalled");
    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> em.n == 2'd0)
        else $error("tokens produced without a byte");
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (byte_reg == ct_pkg::CH_NUL || byte_reg == ct_pkg::CH_EOT))
        |-> em.n != 2'd0)
        else $error("end of text without an end token");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_c_source_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_source_tokenizer
// Self-checking bench: streams source bytes with random gaps, predicts every
// token in a scoreboard and compares each token beat field by field.
// ----------------------------------------------------------------------------
module tb_c_source_tokenizer;

    localparam int NEST_LIMIT = 255;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] pos;
        logic [23:0] len;
        logic [23:0] line;
        logic [23:0] col;
        logic [15:0] file;
        logic [63:0] hash;
        logic        last;
    } token_rec_t;

    // Scoreboard: its own copy of the scanner state; notes accepted bytes and
    // checks token beats against the oldest predicted token.
    class token_scoreboard;
        ct_pkg::mode_t mode;
        logic [23:0] tstart, tcount, tline, tcol;
        logic [23:0] bpos, cline, ccol, spos, sline, scol;
        logic [63:0] rhash;
        logic [15:0] prior;
        logic [15:0] file_no;
        int unsigned depth;
        int          errors;
        token_rec_t  run[$];
        token_rec_t  pending_tokens[$];

        function new();
            file_no = 0;
            errors = 0;
            clear();
        endfunction

        function void clear();
            mode = ct_pkg::M_IDLE;
            tstart = 0; tcount = 0; tline = 0; tcol = 0;
            bpos = 0; cline = 0; ccol = 0; spos = 0; sline = 0; scol = 0;
            rhash = 0; prior = 0; depth = 0;
        endfunction

        function logic [23:0] sat(logic [23:0] v);
            return (v == 24'hFFFFFF) ? v : v + 24'd1;
        endfunction

        function logic [63:0] sext(logic [7:0] b);
            return {{56{b[7]}}, b};
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == " " || b == 8'h09 || b == 8'h0D || b == ct_pkg::CH_NL
                || b == 8'h0C;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_word(logic [7:0] b);
            return is_digit(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z")
                || b == "_";
        endfunction

        function logic [5:0] punct_code(logic [7:0] b);
            string marks;
            marks = ";\\{}()[]~!$%^&*|.,?:+-/=><";
            for (int i = 0; i < marks.len(); i++)
                if (marks[i] == b) return 6'(i + 1);
            return ct_pkg::K_UNKNOWN;
        endfunction

        function void push_token(logic [5:0] k, logic [23:0] p, logic [23:0] n,
                                 logic [23:0] l, logic [23:0] c, logic [63:0] h);
            token_rec_t r;
            if (run.size() >= 3) return;
            r.kind = k; r.pos = p; r.len = n; r.line = l; r.col = c;
            r.file = file_no; r.hash = h; r.last = 1'b0;
            run.push_back(r);
        endfunction

        function void push_text(logic [5:0] k);
            push_token(k, tstart, tcount, tline, tcol, rhash);
        endfunction

        function void push_dollar();
            push_token(ct_pkg::K_DOLLAR, tstart, 24'd1, tline, tcol, sext(ct_pkg::CH_DOLLAR));
        endfunction

        function void push_slash();
            push_token(ct_pkg::K_DIVIDE, spos, 24'd1, sline, scol, sext(ct_pkg::CH_SLASH));
        endfunction

        function void open_text(logic [23:0] p, logic [23:0] l, logic [23:0] c);
            tstart = p; tline = l; tcol = c; rhash = 0; tcount = 0;
        endfunction

        function void open_after();
            open_text(sat(bpos), cline, sat(ccol));
        endfunction

        function void add(logic [7:0] b);
            rhash = rhash * 64'd65599 + sext(b);
            tcount = sat(tcount);
        endfunction

        function void hold_slash();
            spos = bpos; sline = cline; scol = ccol;
        endfunction

        function void scan_idle(logic [7:0] b);
            if (is_blank(b)) return;
            if (b == ct_pkg::CH_SLASH)
            begin
                hold_slash(); mode = ct_pkg::M_SLASH;
            end
            else if (b == ct_pkg::CH_HASH)
            begin
                open_after(); mode = ct_pkg::M_DIR;
            end
            else if (b == ct_pkg::CH_DOLLAR)
            begin
                open_text(bpos, cline, ccol); mode = ct_pkg::M_DOL;
            end
            else if (b == ct_pkg::CH_SQUOTE)
            begin
                open_after(); mode = ct_pkg::M_CHAR_FIRST;
            end
            else if (b == ct_pkg::CH_DQUOTE)
            begin
                open_after(); mode = ct_pkg::M_STR;
            end
            else if (is_word(b))
            begin
                open_text(bpos, cline, ccol);
                add(b);
                mode = is_digit(b) ? ct_pkg::M_NUM : ct_pkg::M_IDENT;
            end
            else push_token(punct_code(b), bpos, 24'd1, cline, ccol, sext(b));
        endfunction

        function void scan(logic [7:0] b);
            logic [7:0] p1, p2;
            bit again;
            p1 = prior[7:0];
            p2 = prior[15:8];
            again = 1;
            while (again)
            begin
                again = 0;
                case (mode)
                    ct_pkg::M_IDLE: scan_idle(b);
                    ct_pkg::M_SLASH:
                        if (b == ct_pkg::CH_STAR) mode = ct_pkg::M_BLOCK;
                        else if (b == ct_pkg::CH_SLASH) mode = ct_pkg::M_LINE;
                        else
                        begin
                            push_slash(); mode = ct_pkg::M_IDLE; again = 1;
                        end
                    ct_pkg::M_BLOCK: if (b == ct_pkg::CH_STAR) mode = ct_pkg::M_BLOCK_STAR;
                    ct_pkg::M_BLOCK_STAR:
                        if (b == ct_pkg::CH_SLASH) mode = ct_pkg::M_IDLE;
                        else if (b != ct_pkg::CH_STAR) mode = ct_pkg::M_BLOCK;
                    ct_pkg::M_LINE: if (b == ct_pkg::CH_NL) mode = ct_pkg::M_IDLE;
                    ct_pkg::M_DIR:
                        if (b == ct_pkg::CH_NL)
                        begin
                            push_text(ct_pkg::K_DIRECTIVE); mode = ct_pkg::M_IDLE; again = 1;
                        end
                        else if (b == ct_pkg::CH_BSLASH)
                        begin
                            add(b); mode = ct_pkg::M_DIR_ESC;
                        end
                        else if (b == ct_pkg::CH_SLASH) mode = ct_pkg::M_DIR_SLASH;
                        else add(b);
                    ct_pkg::M_DIR_ESC: begin add(b); mode = ct_pkg::M_DIR; end
                    ct_pkg::M_DIR_SLASH:
                        if (b == ct_pkg::CH_SLASH)
                        begin
                            push_text(ct_pkg::K_DIRECTIVE); mode = ct_pkg::M_LINE;
                        end
                        else if (b == ct_pkg::CH_STAR)
                        begin
                            add(ct_pkg::CH_SLASH); add(b); mode = ct_pkg::M_DIR_BLOCK;
                        end
                        else
                        begin
                            add(ct_pkg::CH_SLASH); mode = ct_pkg::M_DIR; again = 1;
                        end
                    ct_pkg::M_DIR_BLOCK:
                    begin
                        add(b);
                        if (b == ct_pkg::CH_STAR) mode = ct_pkg::M_DIR_BLOCK_STAR;
                    end
                    ct_pkg::M_DIR_BLOCK_STAR:
                    begin
                        add(b);
                        if (b == ct_pkg::CH_SLASH) mode = ct_pkg::M_DIR;
                        else if (b != ct_pkg::CH_STAR) mode = ct_pkg::M_DIR_BLOCK;
                    end
                    ct_pkg::M_DOL:
                        if (is_blank(b)) ;
                        else if (b == ct_pkg::CH_SLASH)
                        begin
                            hold_slash(); mode = ct_pkg::M_DOL_SLASH;
                        end
                        else if (b == ct_pkg::CH_LPAREN)
                        begin
                            open_after(); depth = 0; mode = ct_pkg::M_META;
                        end
                        else
                        begin
                            push_dollar(); mode = ct_pkg::M_IDLE; again = 1;
                        end
                    ct_pkg::M_DOL_SLASH:
                        if (b == ct_pkg::CH_STAR) mode = ct_pkg::M_DOL_BLOCK;
                        else if (b == ct_pkg::CH_SLASH) mode = ct_pkg::M_DOL_LINE;
                        else
                        begin
                            push_dollar(); push_slash(); mode = ct_pkg::M_IDLE; again = 1;
                        end
                    ct_pkg::M_DOL_BLOCK:
                        if (b == ct_pkg::CH_STAR) mode = ct_pkg::M_DOL_BLOCK_STAR;
                    ct_pkg::M_DOL_BLOCK_STAR:
                        if (b == ct_pkg::CH_SLASH) mode = ct_pkg::M_DOL;
                        else if (b != ct_pkg::CH_STAR) mode = ct_pkg::M_DOL_BLOCK;
                    ct_pkg::M_DOL_LINE: if (b == ct_pkg::CH_NL) mode = ct_pkg::M_DOL;
                    ct_pkg::M_META:
                        if (b == ct_pkg::CH_RPAREN && depth == 0)
                        begin
                            push_text(ct_pkg::K_META); mode = ct_pkg::M_IDLE;
                        end
                        else
                        begin
                            if (b == ct_pkg::CH_RPAREN) depth--;
                            else if (b == ct_pkg::CH_LPAREN && depth < NEST_LIMIT) depth++;
                            add(b);
                        end
                    ct_pkg::M_CHAR_FIRST: begin add(b); mode = ct_pkg::M_CHAR; end
                    ct_pkg::M_CHAR:
                        if (b == ct_pkg::CH_SQUOTE
                            && (p1 != ct_pkg::CH_BSLASH || p2 == ct_pkg::CH_BSLASH))
                        begin
                            push_text(ct_pkg::K_CHAR); mode = ct_pkg::M_IDLE;
                        end
                        else add(b);
                    ct_pkg::M_STR:
                        if (b == ct_pkg::CH_DQUOTE && p1 != ct_pkg::CH_BSLASH)
                        begin
                            push_text(ct_pkg::K_STRING); mode = ct_pkg::M_IDLE;
                        end
                        else add(b);
                    ct_pkg::M_NUM:
                        if (is_digit(b)) add(b);
                        else
                        begin
                            push_text(ct_pkg::K_NUMBER); mode = ct_pkg::M_IDLE; again = 1;
                        end
                    ct_pkg::M_IDENT:
                        if (is_word(b)) add(b);
                        else
                        begin
                            push_text(ct_pkg::K_IDENT); mode = ct_pkg::M_IDLE; again = 1;
                        end
                    default: begin mode = ct_pkg::M_IDLE; again = 1; end
                endcase
            end
            bpos = sat(bpos);
            if (b == ct_pkg::CH_NL) begin cline = sat(cline); ccol = 0; end
            else ccol = sat(ccol);
            prior = {prior[7:0], b};
        endfunction

        function void end_text();
            case (mode) inside
                ct_pkg::M_SLASH: push_slash();
                ct_pkg::M_DIR, ct_pkg::M_DIR_ESC, ct_pkg::M_DIR_BLOCK,
                ct_pkg::M_DIR_BLOCK_STAR:
                    push_text(ct_pkg::K_DIRECTIVE);
                ct_pkg::M_DIR_SLASH:
                begin
                    add(ct_pkg::CH_SLASH); push_text(ct_pkg::K_DIRECTIVE);
                end
                ct_pkg::M_DOL, ct_pkg::M_DOL_BLOCK, ct_pkg::M_DOL_BLOCK_STAR,
                ct_pkg::M_DOL_LINE:
                    push_dollar();
                ct_pkg::M_DOL_SLASH: begin push_dollar(); push_slash(); end
                ct_pkg::M_META: push_text(ct_pkg::K_META);
                ct_pkg::M_CHAR_FIRST, ct_pkg::M_CHAR: push_text(ct_pkg::K_CHAR);
                ct_pkg::M_STR: push_text(ct_pkg::K_STRING);
                ct_pkg::M_NUM: push_text(ct_pkg::K_NUMBER);
                ct_pkg::M_IDENT: push_text(ct_pkg::K_IDENT);
                default: ;
            endcase
            push_token(ct_pkg::K_END, bpos, 24'd0, cline, ccol, 64'd0);
            clear();
        endfunction

        // Note one accepted byte beat and queue the tokens it completes.
        function void note_byte(logic [7:0] b);
            run.delete();
            if (b == ct_pkg::CH_NUL || b == ct_pkg::CH_EOT) end_text();
            else scan(b);
            if (run.size() > 0) run[run.size() - 1].last = 1'b1;
            foreach (run[i]) pending_tokens.push_back(run[i]);
        endfunction

        task report(string msg);
            $display("%0t tokenizer mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Check one token beat against the oldest prediction.
        task check_token(token_rec_t got);
            token_rec_t want;
            if (pending_tokens.size() == 0)
            begin
                report($sformatf("unexpected token kind %0d", got.kind));
                return;
            end
            want = pending_tokens.pop_front();
            check_field("token_kind", got.kind, want.kind);
            check_field("start_position", got.pos, want.pos);
            check_field("token_length", got.len, want.len);
            check_field("line_number", got.line, want.line);
            check_field("column_number", got.col, want.col);
            check_field("source_file", got.file, want.file);
            check_field("text_hash", got.hash, want.hash);
            check_field("last_of_run", got.last, want.last);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    bit          no_idle;

    ct_text_if  text ();
    ct_token_if token ();

    token_scoreboard board;

    c_source_tokenizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .text     (text.sink),
        .token    (token.source)
    );

    always #1 clk = ~clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Token sink: sample the beat at the edge, then choose ready for the next.
    int stall_left;
    always @(posedge clk)
    begin
        token_rec_t got;
        if (rst_n && token.valid && token.ready)
        begin
            got.kind = token.token_kind;
            got.pos  = token.start_position;
            got.len  = token.token_length;
            got.line = token.line_number;
            got.col  = token.column_number;
            got.file = token.source_file;
            got.hash = token.text_hash;
            got.last = token.last_of_run;
            board.check_token(got);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            token.ready <= 1'b0;
        end
        else
        begin
            token.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Drive one byte beat, holding it until the block takes it.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text.valid     <= 1'b1;
        text.text_byte <= b;
        do @(posedge clk); while (!text.ready);
        board.note_byte(b);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Drain all predicted tokens, then allow for bytes still in flight.
    task automatic wait_drained();
        text.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_file_number(logic [15:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.file_no = v;
    endtask

    function automatic string word_text(bit digits);
        string s, a;
        int n;
        s = "";
        a = digits ? "0123456789" : "abcxyzABQZ_09";
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) s = {s, string'(a[$urandom_range(a.len() - 1)])};
        return s;
    endfunction

    // One random fragment of C-like text; mostly well formed, some noise.
    // An empty fragment stands for a NUL byte, which a string cannot hold.
    function automatic string fragment();
        string s;
        logic [7:0] rb;
        case ($urandom_range(13))
            0, 1: s = {word_text(0), " "};
            2:    s = word_text(1);
            3:    s = {"\"", word_text(0), "\\\"", word_text(0), "\""};
            4:
            begin
                if ($urandom_range(1)) s = "'\\''";
                else s = {"'", word_text(0), "'"};
            end
            5:    s = {"/*", word_text(0), "**/"};
            6:    s = {"//", word_text(0), "\n"};
            7:
            begin
                s = {"#def ", word_text(0), "\\\n/*x*/ a/b"};
                if ($urandom_range(1)) s = {s, "\n"};
                else s = {s, "//c\n"};
            end
            8:    s = {"$ (", word_text(0), "(", word_text(1), "))"};
            9:
            begin
                if ($urandom_range(1)) s = "$/**/x";
                else s = "$/y";
            end
            10:   s = ";{}()[]~!%^&*|.,?:+-=><\\";
            11:   s = "\t\r\n\f /x";
            12:
            begin
                rb = $urandom_range(1, 254);
                s = string'(rb);
            end
            default:
            begin
                if ($urandom_range(1)) s = "";
                else s = string'(ct_pkg::CH_EOT);
            end
        endcase
        return s;
    endfunction

    initial
    begin
        int sent;
        string s;
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 16'd0;
        no_idle = 1'b0;
        stall_left = 0;
        text.valid = 1'b0;
        text.text_byte = 8'd0;
        token.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every punctuation kind, words, comments, directive with
        // escape and inner comment, metaprogram with nesting, lone dollar and
        // dollar before a slash, literals with backslashes, high bytes.
        write_file_number(16'hFFFF);
        send_text("a_Z9 123;\\{}()[]~!$%^&*|.,?:+-/=><@ /*c*/ //x\n");
        send_text("#in\\\nc /* k */ q // r\n$ /*c*/ ( a (b) ) $x$/ ");
        send_text("'a' '\\'' '\\\\' \"s\\\"t\" ");
        send_byte(8'h80);
        send_byte(8'hFE);
        send_byte(8'h7F);
        send_text("\"open");
        send_byte(ct_pkg::CH_EOT);
        send_text("$/");
        send_byte(ct_pkg::CH_NUL);
        wait_drained();

        // Random phases at several file numbers, one without any idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_file_number(16'h0000);
                1: write_file_number(16'h8001);
                default: write_file_number(16'($urandom_range(0, 65535)));
            endcase
            no_idle = (ph == 2);
            sent = 0;
            while (sent < 50)
            begin
                s = fragment();
                if (s.len() == 0)
                begin
                    send_byte(ct_pkg::CH_NUL);
                    sent++;
                end
                else
                begin
                    send_text(s);
                    sent += s.len();
                end
            end
            wait_drained();
        end

        if (board.errors == 0)
            $display("tb_c_source_tokenizer: done, clean");
        else
            $display("tb_c_source_tokenizer: done, errors");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb_c_source_tokenizer: done, errors");
        $finish;
    end

endmodule
